FILE: rtl/ptc_pkg.sv
// Shared constants, types and lookup functions for the pixel to terminal cell block.
// Depends on nothing; included by wildcard import in rtl/pixel_to_terminal_cell.sv.
package ptc_pkg;

  // Pixel and result field widths
  localparam int unsigned ChanW   = 8;
  localparam int unsigned IdxW    = 4;
  localparam int unsigned CodeW   = 7;
  localparam int unsigned GlyphW  = 6;
  localparam int unsigned GcW     = 7;

  // Palette geometry
  localparam int unsigned PalSize = 16;
  localparam int unsigned NumLvl  = 4;
  localparam int unsigned NumChan = 3;
  localparam int unsigned GroupSz = 4;
  localparam int unsigned NumGrp  = PalSize / GroupSz;

  // Arithmetic widths
  localparam int unsigned SqW     = 2 * ChanW;       // one squared channel difference
  localparam int unsigned DistW   = SqW + 2;         // sum of three squares
  localparam int unsigned SumW    = ChanW + 2;       // r + g + b
  localparam int unsigned ProdW   = GlyphW + SumW;   // (glyph count - 1) * sum
  localparam int unsigned RecipW  = 17;
  localparam int unsigned MulW    = ProdW + RecipW;

  // Glyph count limits
  localparam logic [GcW-1:0] GcReset = 7'd64;
  localparam logic [GcW-1:0] GcMax   = 7'd64;

  // Exact floor(p / 765) for p below 48196: (p * ceil(2^26 / 765)) >> 26
  localparam int unsigned     RecipSh = 26;
  localparam logic [RecipW-1:0] Recip765 = 17'd87725;

  // Register map
  localparam logic RegGlyphCount = 1'b0;

  // Channel levels used by the palette
  typedef logic [ChanW-1:0] chan_t;
  typedef logic [SqW-1:0]   sq_t;
  typedef logic [DistW-1:0] dist_t;
  typedef logic [IdxW-1:0]  idx_t;
  typedef logic [1:0]       lvl_t;

  localparam chan_t LvlVal [NumLvl] = '{8'd0, 8'd85, 8'd170, 8'd255};

  // Level code of one channel of one palette entry
  function automatic lvl_t pal_lvl(input idx_t idx, input int unsigned ch);
    logic [5:0] row;
    begin
      unique case (idx)
        4'd0:    row = {2'd0, 2'd0, 2'd0};
        4'd1:    row = {2'd2, 2'd0, 2'd0};
        4'd2:    row = {2'd0, 2'd2, 2'd0};
        4'd3:    row = {2'd2, 2'd1, 2'd0};
        4'd4:    row = {2'd0, 2'd0, 2'd2};
        4'd5:    row = {2'd2, 2'd0, 2'd2};
        4'd6:    row = {2'd0, 2'd2, 2'd2};
        4'd7:    row = {2'd2, 2'd2, 2'd2};
        4'd8:    row = {2'd1, 2'd1, 2'd1};
        4'd9:    row = {2'd3, 2'd1, 2'd1};
        4'd10:   row = {2'd1, 2'd3, 2'd1};
        4'd11:   row = {2'd3, 2'd3, 2'd1};
        4'd12:   row = {2'd1, 2'd1, 2'd3};
        4'd13:   row = {2'd3, 2'd1, 2'd3};
        4'd14:   row = {2'd1, 2'd3, 2'd3};
        default: row = {2'd3, 2'd3, 2'd3};
      endcase
      // Red sits in the top two bits, blue in the bottom two
      pal_lvl = row[(2 - ch) * 2 +: 2];
    end
  endfunction

  // Terminal background code: 40..47 for the normal colours, 100..107 for bright
  function automatic logic [CodeW-1:0] pal_code(input idx_t idx);
    begin
      if (idx[3]) begin
        pal_code = CodeW'(7'd100 + {4'd0, idx[2:0]});
      end else begin
        pal_code = CodeW'(7'd40 + {4'd0, idx[2:0]});
      end
    end
  endfunction

endpackage

FILE: rtl/pixel_to_terminal_cell.sv
// Top level of the pixel to terminal cell block: nearest 16-colour palette match and shade.
// Depends on rtl/ptc_pkg.sv for constants, types and palette lookup functions.
//
//   Channel   Direction  Handshake            Payload
//   in_       sink       in_valid / in_stall   in_red, in_green, in_blue (8 bits each)
//   out_      source     out_valid / out_stall out_palette_index, out_ansi_code, out_glyph_index
//   APB       slave      psel/penable/pready   glyph_count at byte address 0
//
// One pixel enters per clock unless the input is stalled; its result reaches the output through the stages.
// The four stages are: channel squares, distances and shade product, group minima and
// reciprocal multiply, final minimum into the output register.
// Reset (rst_n low, synchronous) empties the pipeline and sets glyph_count to 64.
// A stall on the output holds each occupied stage with no empty stage ahead; empty stages still fill, so bubbles close.
module pixel_to_terminal_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  ptc_pkg::chan_t            in_red,
  input  ptc_pkg::chan_t            in_green,
  input  ptc_pkg::chan_t            in_blue,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [ptc_pkg::IdxW-1:0]  out_palette_index,
  output logic [ptc_pkg::CodeW-1:0] out_ansi_code,
  output logic [ptc_pkg::GlyphW-1:0] out_glyph_index,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import ptc_pkg::*;

  // Configuration register
  logic [GcW-1:0]    gc_r;
  logic [GlyphW-1:0] gcm1;

  // Stage valid bits and ready chain
  logic s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic out_rdy, s3_rdy, s2_rdy, s1_rdy;

  // Stage 1: squared channel differences against the four levels
  sq_t                sq_nxt [NumChan][NumLvl];
  sq_t                sq_r   [NumChan][NumLvl];
  logic [SumW-1:0]    sum_nxt, sum_r;
  logic [GlyphW-1:0]  gcm1_r;

  // Stage 2: palette distances and shade product
  dist_t              dist_nxt [PalSize];
  dist_t              dist_r   [PalSize];
  logic [ProdW-1:0]   prod_nxt, prod_r;

  // Stage 3: group minima and shade quotient
  dist_t              gdist_nxt [NumGrp];
  dist_t              gdist_r   [NumGrp];
  idx_t               gidx_nxt  [NumGrp];
  idx_t               gidx_r    [NumGrp];
  logic [MulW-1:0]    mul_full;
  logic [GlyphW-1:0]  shade_nxt, shade_r;

  // Stage 4: output register
  idx_t               best_idx_nxt;
  dist_t              best_dist;
  idx_t               idx_r;
  logic [CodeW-1:0]   code_r;
  logic [GlyphW-1:0]  glyph_r;

  // APB register access; the register is decoded on the word address bit only
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegGlyphCount) ? {{(32 - GcW){1'b0}}, gc_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gc_r <= GcReset;
    end else if (psel && penable && pwrite && pready && (paddr[2] == RegGlyphCount)) begin
      gc_r <= pwdata[GcW-1:0];
    end
  end

  // Effective glyph count minus one: zero counts as one, above 64 saturates
  always_comb begin
    if (gc_r == '0) begin
      gcm1 = '0;
    end else if (gc_r > GcMax) begin
      gcm1 = GlyphW'(GcMax - 7'd1);
    end else begin
      gcm1 = GlyphW'(gc_r - 7'd1);
    end
  end

  // Ready chain: a stage moves when it is empty or the next stage moves
  assign out_rdy  = !out_v_r || !out_stall;
  assign s3_rdy   = !s3_v_r || out_rdy;
  assign s2_rdy   = !s2_v_r || s3_rdy;
  assign s1_rdy   = !s1_v_r || s2_rdy;
  assign in_stall = !s1_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_rdy)  s1_v_r  <= in_valid;
      if (s2_rdy)  s2_v_r  <= s1_v_r;
      if (s3_rdy)  s3_v_r  <= s2_v_r;
      if (out_rdy) out_v_r <= s3_v_r;
    end
  end

  // Stage 1 logic: absolute difference and square per channel and level
  always_comb begin
    chan_t x;
    chan_t d;
    for (int ch = 0; ch < NumChan; ch++) begin
      x = (ch == 0) ? in_red : ((ch == 1) ? in_green : in_blue);
      for (int l = 0; l < NumLvl; l++) begin
        d = (x >= LvlVal[l]) ? (x - LvlVal[l]) : (LvlVal[l] - x);
        sq_nxt[ch][l] = SqW'(d) * SqW'(d);
      end
    end
    sum_nxt = SumW'(in_red) + SumW'(in_green) + SumW'(in_blue);
  end

  always_ff @(posedge clk) begin
    if (in_valid && s1_rdy) begin
      sq_r   <= sq_nxt;
      sum_r  <= sum_nxt;
      gcm1_r <= gcm1;
    end
  end

  // Stage 2 logic: each palette distance is a sum of three looked-up squares
  always_comb begin
    for (int c = 0; c < PalSize; c++) begin
      dist_nxt[c] = DistW'(sq_r[0][pal_lvl(IdxW'(c), 0)])
                  + DistW'(sq_r[1][pal_lvl(IdxW'(c), 1)])
                  + DistW'(sq_r[2][pal_lvl(IdxW'(c), 2)]);
    end
    prod_nxt = ProdW'(gcm1_r) * ProdW'(sum_r);
  end

  always_ff @(posedge clk) begin
    if (s1_v_r && s2_rdy) begin
      dist_r <= dist_nxt;
      prod_r <= prod_nxt;
    end
  end

  // Stage 3 logic: minimum within each group of four, lower index kept on a tie
  always_comb begin
    for (int g = 0; g < NumGrp; g++) begin
      gdist_nxt[g] = dist_r[g * GroupSz];
      gidx_nxt[g]  = IdxW'(g * GroupSz);
      for (int k = 1; k < GroupSz; k++) begin
        if (dist_r[g * GroupSz + k] < gdist_nxt[g]) begin
          gdist_nxt[g] = dist_r[g * GroupSz + k];
          gidx_nxt[g]  = IdxW'(g * GroupSz + k);
        end
      end
    end
    // Division by 765 as a multiplication by its scaled reciprocal
    mul_full  = MulW'(prod_r) * MulW'(Recip765);
    shade_nxt = mul_full[RecipSh +: GlyphW];
  end

  always_ff @(posedge clk) begin
    if (s2_v_r && s3_rdy) begin
      gdist_r <= gdist_nxt;
      gidx_r  <= gidx_nxt;
      shade_r <= shade_nxt;
    end
  end

  // Stage 4 logic: minimum across the groups, then the terminal code lookup
  always_comb begin
    best_dist    = gdist_r[0];
    best_idx_nxt = gidx_r[0];
    for (int g = 1; g < NumGrp; g++) begin
      if (gdist_r[g] < best_dist) begin
        best_dist    = gdist_r[g];
        best_idx_nxt = gidx_r[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s3_v_r && out_rdy) begin
      idx_r   <= best_idx_nxt;
      code_r  <= pal_code(best_idx_nxt);
      glyph_r <= shade_r;
    end
  end

  assign out_valid         = out_v_r;
  assign out_palette_index = idx_r;
  assign out_ansi_code     = code_r;
  assign out_glyph_index   = glyph_r;

  // The code shown always belongs to the index shown.
  a_code_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_ansi_code == pal_code(out_palette_index)))
    else $error("ansi code does not match palette index");

  // The shade never reaches the glyph count.
  a_glyph_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_glyph_index <= gcm1))
    else $error("glyph index beyond glyph count");

  // The input is held back only when every stage is occupied.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_v_r && s2_v_r && s3_v_r && out_v_r && out_stall))
    else $error("input stalled with room in the pipeline");

endmodule

FILE: tb/ptc_cell_checker.sv
// Scoreboard for the pixel to terminal cell block: predicts every result beat and compares it.
// Depends on rtl/ptc_pkg.sv for field widths, types and the register index.
module ptc_cell_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  ptc_pkg::chan_t              in_red,
  input  ptc_pkg::chan_t              in_green,
  input  ptc_pkg::chan_t              in_blue,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [ptc_pkg::IdxW-1:0]    out_palette_index,
  input  logic [ptc_pkg::CodeW-1:0]   out_ansi_code,
  input  logic [ptc_pkg::GlyphW-1:0]  out_glyph_index,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  input  logic [31:0]                 prdata,
  input  logic                        pready,
  output int                          errors,
  output int                          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import ptc_pkg::*;

  localparam logic [2:0] GlyphAddr = 3'(4 * RegGlyphCount);

  // The sixteen terminal colours as 0xRRGGBB, with their background codes
  localparam logic [23:0] PalRgb [16] = '{
    24'h000000, 24'hAA0000, 24'h00AA00, 24'hAA5500,
    24'h0000AA, 24'hAA00AA, 24'h00AAAA, 24'hAAAAAA,
    24'h555555, 24'hFF5555, 24'h55FF55, 24'hFFFF55,
    24'h5555FF, 24'hFF55FF, 24'h55FFFF, 24'hFFFFFF};
  localparam logic [6:0] PalAnsi [16] = '{
    7'd40, 7'd41, 7'd42, 7'd43, 7'd44, 7'd45, 7'd46, 7'd47,
    7'd100, 7'd101, 7'd102, 7'd103, 7'd104, 7'd105, 7'd106, 7'd107};

  typedef struct packed {
    logic [IdxW-1:0]   colour;
    logic [CodeW-1:0]  code;
    logic [GlyphW-1:0] shade;
  } cell_t;

  cell_t             expected_cells [$];
  logic [GcW-1:0]    glyph_count_q;

  initial begin
    errors  = 0;
    pending = 0;
  end

  // Nearest colour by squared distance (first minimum wins) and the brightness shade.
  function automatic cell_t nearest_cell(input chan_t r, input chan_t g, input chan_t b,
                                         input logic [GcW-1:0] gc);
    cell_t       pick;
    int          best;
    int          sqdist;
    int          dr;
    int          dg;
    int          db;
    int unsigned shades;
    best        = 32'h7fffffff;
    pick.colour = '0;
    for (int c = 0; c < 16; c++) begin
      dr     = int'(r) - int'(PalRgb[c][23:16]);
      dg     = int'(g) - int'(PalRgb[c][15:8]);
      db     = int'(b) - int'(PalRgb[c][7:0]);
      sqdist = dr * dr + dg * dg + db * db;
      if (sqdist < best) begin
        best        = sqdist;
        pick.colour = IdxW'(c);
      end
    end
    pick.code = PalAnsi[pick.colour];
    // A count of zero behaves as one, anything above 64 as 64
    shades = gc;
    if (shades == 0) shades = 1;
    if (shades > 64) shades = 64;
    pick.shade = GlyphW'(((shades - 1) * (int'(r) + int'(g) + int'(b))) / 765);
    return pick;
  endfunction

  task automatic report_mismatch(input string what);
    errors = errors + 1;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Predict on each input beat, compare on each output beat, mirror the register.
  always @(posedge clk) begin
    cell_t want;
    if (!rst_n) begin
      expected_cells.delete();
      glyph_count_q <= 7'd64;
    end else begin
      if (in_valid && !in_stall) begin
        expected_cells.push_back(nearest_cell(in_red, in_green, in_blue, glyph_count_q));
      end
      if (out_valid && !out_stall) begin
        if (expected_cells.size() == 0) begin
          report_mismatch("result beat arrived with no pixel outstanding");
        end else begin
          want = expected_cells.pop_front();
          if (out_palette_index !== want.colour)
            report_mismatch($sformatf("palette_index got %0d want %0d",
                                      out_palette_index, want.colour));
          if (out_ansi_code !== want.code)
            report_mismatch($sformatf("ansi_code got %0d want %0d",
                                      out_ansi_code, want.code));
          if (out_glyph_index !== want.shade)
            report_mismatch($sformatf("glyph_index got %0d want %0d",
                                      out_glyph_index, want.shade));
        end
      end
      if (psel && penable && pready && paddr == GlyphAddr) begin
        if (pwrite) begin
          glyph_count_q <= pwdata[GcW-1:0];
        end else if (prdata !== {{(32 - GcW){1'b0}}, glyph_count_q}) begin
          report_mismatch($sformatf("glyph_count read %0d want %0d", prdata, glyph_count_q));
        end
      end
    end
    pending = expected_cells.size();
  end

endmodule

FILE: tb/tb_pixel_to_terminal_cell.sv
// Top of the pixel to terminal cell testbench: clock, reset, pixel stimulus and verdict.
// Depends on rtl/ptc_pkg.sv, rtl/pixel_to_terminal_cell.sv and tb/ptc_cell_checker.sv.
module tb_pixel_to_terminal_cell;
  timeunit 1ns;
  timeprecision 1ps;

  import ptc_pkg::*;

  localparam logic [2:0] GlyphAddr  = 3'(4 * RegGlyphCount);
  localparam int         CycleLimit = 300000;

  // Palette colours, exact ties between neighbours and a few edge sums
  localparam logic [23:0] DirectedPixels [24] = '{
    24'h000000, 24'hAA0000, 24'h00AA00, 24'hAA5500,
    24'h0000AA, 24'hAA00AA, 24'h00AAAA, 24'hAAAAAA,
    24'h555555, 24'hFF5555, 24'h55FF55, 24'hFFFF55,
    24'h5555FF, 24'hFF55FF, 24'h55FFFF, 24'hFFFFFF,
    24'h550000, 24'hFFAA55, 24'hFF0000, 24'h00FFFF,
    24'h010203, 24'hFEFEFE, 24'h808080, 24'h2A2B2B};

  // Glyph counts per phase: zero, one, the top of the field, just past 64, and so on
  localparam logic [6:0] GlyphPlan [8] = '{
    7'd0, 7'd1, 7'd127, 7'd65, 7'd2, 7'd63, 7'd64, 7'd64};

  // Stall density of each receiver segment, in percent
  localparam int StallPct [4] = '{0, 25, 60, 90};

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  chan_t                in_red    = '0;
  chan_t                in_green  = '0;
  chan_t                in_blue   = '0;
  logic                 out_stall = 1'b0;
  logic                 psel      = 1'b0;
  logic                 penable   = 1'b0;
  logic                 pwrite    = 1'b0;
  logic [2:0]           paddr     = '0;
  logic [31:0]          pwdata    = '0;
  logic                 in_stall;
  logic                 out_valid;
  logic [IdxW-1:0]      out_palette_index;
  logic [CodeW-1:0]     out_ansi_code;
  logic [GlyphW-1:0]    out_glyph_index;
  logic [31:0]          prdata;
  logic                 pready;
  int                   errors;
  int                   pending;
  int                   cycle_count = 0;
  bit                   flood_req   = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  pixel_to_terminal_cell i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_red            (in_red),
    .in_green          (in_green),
    .in_blue           (in_blue),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_palette_index (out_palette_index),
    .out_ansi_code     (out_ansi_code),
    .out_glyph_index   (out_glyph_index),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  ptc_cell_checker i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_red            (in_red),
    .in_green          (in_green),
    .in_blue           (in_blue),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_palette_index (out_palette_index),
    .out_ansi_code     (out_ansi_code),
    .out_glyph_index   (out_glyph_index),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .errors            (errors),
    .pending           (pending)
  );

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: segments of varying stall density, plus one long hold while the sender floods.
  initial begin : receiver
    int  seg_len;
    int  pct;
    bit  flood_seen;
    flood_seen = 1'b0;
    forever begin
      if (flood_req && !flood_seen) begin
        flood_seen = 1'b1;
        pct        = 100;
        seg_len    = 80;
      end else begin
        pct     = StallPct[$urandom_range(0, 3)];
        seg_len = $urandom_range(4, 40);
      end
      for (int k = 0; k < seg_len; k++) begin
        @(posedge clk);
        out_stall <= ($urandom_range(0, 99) < pct);
        if (pct != 100 && flood_req && !flood_seen) break;
      end
    end
  end

  // One pixel beat; called at a rising edge and returns at the edge that takes it.
  task automatic push_pixel(input chan_t r, input chan_t g, input chan_t b);
    bit taken;
    in_valid <= 1'b1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
  endtask

  // Channel value near a palette level or a midpoint, at an extreme, or anywhere.
  function automatic chan_t random_level(input int mode);
    int v;
    case (mode)
      0: begin
        v = int'($urandom_range(0, 6)) * 85 / 2 + int'($urandom_range(0, 4)) - 2;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
      end
      1: v = ($urandom_range(0, 1) != 0) ? 255 : 0;
      default: v = $urandom_range(0, 255);
    endcase
    return chan_t'(v);
  endfunction

  task automatic push_random_pixel();
    int mode;
    mode = $urandom_range(0, 7);
    if (mode <= 2) mode = 0;
    else if (mode == 3) mode = 1;
    else mode = 2;
    push_pixel(random_level(mode), random_level(mode), random_level(mode));
  endtask

  // Random bursts separated by random gaps; optionally open with a flood against a held output.
  task automatic run_pixels(input int count, input bit flood);
    int sent;
    int burst;
    int gap;
    sent = 0;
    if (flood) begin
      flood_req = 1'b1;
      repeat (48) push_random_pixel();
      sent = 48;
    end
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && sent < count; k++) begin
        push_random_pixel();
        sent++;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Let every outstanding pixel drain, then allow the pipeline to go quiet.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (6) @(posedge clk);
  endtask

  // One register transfer: setup cycle, then access until pready.
  task automatic reg_access(input bit wr, input logic [31:0] data);
    bit ready;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= GlyphAddr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      ready = pready;
      @(posedge clk);
    end while (!ready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Main sequence: reset, directed pixels, then random phases over several glyph counts.
  initial begin : stimulus
    logic [6:0] glyphs;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Check the reset value of the register before anything is written
    reg_access(1'b0, '0);
    for (int i = 0; i < 24; i++) begin
      push_pixel(DirectedPixels[i][23:16], DirectedPixels[i][15:8], DirectedPixels[i][7:0]);
    end

    for (int p = 0; p < 8; p++) begin
      glyphs = (p == 7) ? 7'($urandom_range(0, 127)) : GlyphPlan[p];
      drain();
      reg_access(1'b1, {25'd0, glyphs});
      reg_access(1'b0, '0);
      // Full-scale and zero brightness under every setting
      push_pixel(8'hFF, 8'hFF, 8'hFF);
      push_pixel(8'h00, 8'h00, 8'h00);
      run_pixels(88, p == 2);
    end

    drain();
    @(negedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/ptc_pkg.sv
rtl/pixel_to_terminal_cell.sv
tb/ptc_cell_checker.sv
tb/tb_pixel_to_terminal_cell.sv
